// ----- design/hri_pkg.sv -----
// Package for the Halton radical inverse unit.
// Holds default sizes, register constants and the sequencer state type.
// No dependencies.
package hri_pkg;

    localparam int DEF_INDEX_WIDTH   = 32;
    localparam int DEF_FRACTION_BITS = 32;

    localparam int RADIX_WIDTH = 8;
    localparam int RESULT_WIDTH = 32;
    localparam int SAMPLE_WIDTH = 32;

    localparam logic [RADIX_WIDTH-1:0] RADIX_RESET = 8'd2;
    localparam logic [RADIX_WIDTH-1:0] RADIX_MIN   = 8'd2;

    // Weight sequencer states, one-hot.
    typedef enum logic [1:0] {
        SEQ_IDLE = 2'b01,
        SEQ_DIV  = 2'b10
    } seq_state_t;

endpackage

// ----- design/hri_weight_seq.sv -----
// Weight and reciprocal sequencer for the Halton radical inverse unit.
// A bit-serial divider builds floor(2^N/b) and the weight table floor(2^F/b^k).
// Depends on hri_pkg.
module hri_weight_seq
    import hri_pkg::*;
#(
    parameter int INDEX_WIDTH   = DEF_INDEX_WIDTH,
    parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_we,
    input  logic [RADIX_WIDTH-1:0]   cfg_wdata,
    output logic                     busy,
    output logic [RADIX_WIDTH-1:0]   base,
    output logic [INDEX_WIDTH-1:0]   recip,
    output logic [FRACTION_BITS-1:0] weight [INDEX_WIDTH]
);

    localparam int N  = INDEX_WIDTH;
    localparam int F  = FRACTION_BITS;
    localparam int D  = INDEX_WIDTH;
    localparam int W  = ((F > N) ? F : N) + 1;
    localparam int SW = $clog2(D + 1);
    localparam int DW = $clog2(D);
    localparam int CW = $clog2(W);

    seq_state_t             state_reg;
    logic [RADIX_WIDTH-1:0] base_reg;
    logic [SW-1:0]          step_reg;
    logic [CW-1:0]          bit_reg;
    logic [W-1:0]           num_reg;
    logic [W-1:0]           quo_reg;
    logic [RADIX_WIDTH-1:0] rem_reg;
    logic [N-1:0]           recip_reg;
    logic [F-1:0]           weight_reg [D];

    logic [RADIX_WIDTH:0]   trial;
    logic                   fits;
    logic [RADIX_WIDTH-1:0] rem_next;
    logic [W-1:0]           quo_next;
    logic [SW-1:0]          wr_step;
    logic [DW-1:0]          wr_idx;
    logic [RADIX_WIDTH-1:0] cfg_sat;

    // One restoring division step per cycle.
    assign trial    = {rem_reg, num_reg[W-1]};
    assign fits     = trial >= {1'b0, base_reg};
    assign rem_next = fits ? RADIX_WIDTH'(trial - {1'b0, base_reg})
                           : trial[RADIX_WIDTH-1:0];
    assign quo_next = {quo_reg[W-2:0], fits};
    assign wr_step  = step_reg - SW'(1);
    assign wr_idx   = wr_step[DW-1:0];
    assign cfg_sat  = (cfg_wdata < RADIX_MIN) ? RADIX_MIN : cfg_wdata;

    // Sequencer: step zero yields the reciprocal, later steps the weights.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= SEQ_DIV;
            base_reg  <= RADIX_RESET;
            step_reg  <= '0;
            bit_reg   <= '0;
            num_reg   <= W'(1) << N;
            quo_reg   <= '0;
            rem_reg   <= '0;
        end else if (cfg_we) begin
            state_reg <= SEQ_DIV;
            base_reg  <= cfg_sat;
            step_reg  <= '0;
            bit_reg   <= '0;
            num_reg   <= W'(1) << N;
            quo_reg   <= '0;
            rem_reg   <= '0;
        end else begin
            case (state_reg)
                SEQ_DIV: begin
                    if (bit_reg == CW'(W - 1)) begin
                        if (step_reg == '0) begin
                            recip_reg <= quo_next[N-1:0];
                            num_reg   <= W'(1) << F;
                        end else begin
                            weight_reg[wr_idx] <= quo_next[F-1:0];
                            num_reg            <= W'(quo_next[F-1:0]);
                        end
                        if (step_reg == SW'(D)) begin
                            state_reg <= SEQ_IDLE;
                        end
                        step_reg <= step_reg + SW'(1);
                        bit_reg  <= '0;
                        quo_reg  <= '0;
                        rem_reg  <= '0;
                    end else begin
                        bit_reg <= bit_reg + CW'(1);
                        num_reg <= {num_reg[W-2:0], 1'b0};
                        quo_reg <= quo_next;
                        rem_reg <= rem_next;
                    end
                end
                default: begin
                    state_reg <= SEQ_IDLE;
                end
            endcase
        end
    end

    assign busy   = (state_reg == SEQ_DIV);
    assign base   = base_reg;
    assign recip  = recip_reg;
    assign weight = weight_reg;

endmodule

// ----- design/hri_digit.sv -----
// One digit of the radical inverse in three register stages.
// Reciprocal multiply, back-multiply, then remainder correction. Depends on hri_pkg.
module hri_digit
    import hri_pkg::*;
#(
    parameter int INDEX_WIDTH   = DEF_INDEX_WIDTH,
    parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     adv,
    input  logic                     in_valid,
    input  logic [INDEX_WIDTH-1:0]   in_idx,
    input  logic [FRACTION_BITS-1:0] in_sum,
    input  logic [RADIX_WIDTH-1:0]   in_digit,
    input  logic [FRACTION_BITS-1:0] in_weight,
    input  logic [INDEX_WIDTH-1:0]   recip,
    input  logic [RADIX_WIDTH-1:0]   base,
    output logic                     out_valid,
    output logic [INDEX_WIDTH-1:0]   out_idx,
    output logic [FRACTION_BITS-1:0] out_sum,
    output logic [RADIX_WIDTH-1:0]   out_digit
);

    localparam int N = INDEX_WIDTH;
    localparam int F = FRACTION_BITS;

    logic           va_reg, vb_reg, vc_reg;
    logic [2*N-1:0] prod_a_reg;
    logic [N-1:0]   idx_a_reg, idx_b_reg, q0_b_reg, qb_b_reg, q_c_reg;
    logic [F-1:0]   sum_a_reg, sum_b_reg, sum_c_reg;
    logic [RADIX_WIDTH-1:0] r_c_reg;

    logic [N-1:0]   q0;
    logic [N-1:0]   r0;
    logic           over;

    assign q0   = prod_a_reg[2*N-1:N];
    assign r0   = idx_b_reg - qb_b_reg;
    assign over = r0 >= N'(base);

    // Valid bits travel with the data.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
        end else if (adv) begin
            va_reg <= in_valid;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
        end
    end

    // Stage a: quotient estimate, and the previous digit's contribution is added.
    // Stage b: back-multiply the estimate by the base.
    // Stage c: the estimate is at most one short; one compare fixes it.
    always_ff @(posedge aclk) begin
        if (adv) begin
            prod_a_reg <= (2*N)'(in_idx) * (2*N)'(recip);
            idx_a_reg  <= in_idx;
            sum_a_reg  <= in_sum + F'(in_weight * in_digit);

            q0_b_reg   <= q0;
            qb_b_reg   <= N'(q0 * N'(base));
            idx_b_reg  <= idx_a_reg;
            sum_b_reg  <= sum_a_reg;

            q_c_reg    <= over ? q0_b_reg + N'(1) : q0_b_reg;
            r_c_reg    <= over ? RADIX_WIDTH'(r0 - N'(base)) : RADIX_WIDTH'(r0);
            sum_c_reg  <= sum_b_reg;
        end
    end

    assign out_valid = vc_reg;
    assign out_idx   = q_c_reg;
    assign out_sum   = sum_c_reg;
    assign out_digit = r_c_reg;

endmodule

// ----- design/halton_radical_inverse_unit.sv -----
// Halton radical inverse unit, top level.
// Each digit takes three register stages, and an output register follows them.
// Throughput: one transaction per cycle once the weight table is built, while m_ready does not hold the output.
// Reset (synchronous, active low) sets the base to 2; reset and every base write
// start a table build during which s_ready is low.
module halton_radical_inverse_unit
    import hri_pkg::*;
#(
    parameter int INDEX_WIDTH   = DEF_INDEX_WIDTH,
    parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_we,
    input  logic [RADIX_WIDTH-1:0]  cfg_wdata,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [SAMPLE_WIDTH-1:0] s_sample_index,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [RESULT_WIDTH-1:0] m_inverse_fraction
);

    localparam int N = INDEX_WIDTH;
    localparam int F = FRACTION_BITS;
    localparam int D = INDEX_WIDTH;

    logic                   busy;
    logic [RADIX_WIDTH-1:0] base;
    logic [N-1:0]           recip;
    logic [F-1:0]           weight [D];
    logic                   adv;

    logic                   v   [D+1];
    logic [N-1:0]           idx [D+1];
    logic [F-1:0]           sum [D+1];
    logic [RADIX_WIDTH-1:0] dig [D+1];
    logic [F-1:0]           wgt [D+1];

    logic                   out_valid_reg;
    logic [F-1:0]           out_sum_reg;
    logic [63:0]            idx_ext;
    logic [63:0]            sum_ext;

    hri_weight_seq #(
        .INDEX_WIDTH  (N),
        .FRACTION_BITS(F)
    ) u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .busy     (busy),
        .base     (base),
        .recip    (recip),
        .weight   (weight)
    );

    // The whole pipeline moves unless a finished result is waiting.
    assign adv     = !out_valid_reg || m_ready;
    assign s_ready = adv && !busy;

    // Pipeline entry: only the low INDEX_WIDTH bits of the index are used.
    assign idx_ext = 64'(s_sample_index);
    assign v[0]    = s_valid && s_ready;
    assign idx[0]  = idx_ext[N-1:0];
    assign sum[0]  = '0;
    assign dig[0]  = '0;
    assign wgt[0]  = '0;

    // One three-stage section per digit.
    for (genvar k = 0; k < D; k++) begin : g_digit
        assign wgt[k+1] = weight[k];
        hri_digit #(
            .INDEX_WIDTH  (N),
            .FRACTION_BITS(F)
        ) u_digit (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .adv      (adv),
            .in_valid (v[k]),
            .in_idx   (idx[k]),
            .in_sum   (sum[k]),
            .in_digit (dig[k]),
            .in_weight(wgt[k]),
            .recip    (recip),
            .base     (base),
            .out_valid(v[k+1]),
            .out_idx  (idx[k+1]),
            .out_sum  (sum[k+1]),
            .out_digit(dig[k+1])
        );
    end

    // Output register adds the last digit's contribution.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            out_valid_reg <= v[D];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            out_sum_reg <= sum[D] + F'(wgt[D] * dig[D]);
        end
    end

    assign sum_ext            = 64'(out_sum_reg);
    assign m_valid            = out_valid_reg;
    assign m_inverse_fraction = sum_ext[RESULT_WIDTH-1:0];

    // No transaction is taken while the weight table is being built.
    a_busy_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        busy |-> !s_ready) else $error("input accepted during table build");

    // A base write always starts a table build.
    a_cfg_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_we |=> busy) else $error("base write did not start table build");

    // A stalled result blocks new input.
    a_stall_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |-> !s_ready) else $error("input taken under stall");

endmodule
